// ===== hdl/vgmcsd_pkg.sv =====
// vgmcsd_pkg: shared types, command codes and tables for the command stream decoder
// no dependencies; used by every module of the block
`default_nettype none

package vgmcsd_pkg;

  // input operations
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_STOPPED = 2'd3;

  // chips
  localparam logic [1:0] CHIP_PSG   = 2'd0;
  localparam logic [1:0] CHIP_SCC   = 2'd1;
  localparam logic [1:0] CHIP_FM    = 2'd2;
  localparam logic [1:0] CHIP_AUDIO = 2'd3;

  // command bytes
  localparam logic [7:0] CMD_PSG       = 8'hA0;
  localparam logic [7:0] CMD_SCC       = 8'hD2;
  localparam logic [7:0] CMD_FM        = 8'h51;
  localparam logic [7:0] CMD_AUDIO     = 8'h5C;
  localparam logic [7:0] CMD_WAIT      = 8'h61;
  localparam logic [7:0] CMD_WAIT_60HZ = 8'h62;
  localparam logic [7:0] CMD_WAIT_50HZ = 8'h63;
  localparam logic [7:0] CMD_END       = 8'h66;
  localparam logic [3:0] CMD_SHORT_HI  = 4'h7;

  localparam logic [15:0] SAMPLES_60HZ = 16'd735;
  localparam logic [15:0] SAMPLES_50HZ = 16'd882;

  // audio chip register handling
  localparam logic [7:0] AUD_REG_A    = 8'h04;
  localparam logic [7:0] AUD_REG_B    = 8'h18;
  localparam logic [7:0] AUD_REG_C    = 8'h19;
  localparam logic [7:0] AUD_REG_MASK = 8'h08;
  localparam logic [7:0] AUD_MASK     = 8'hC4;

  // configuration register indexes
  localparam logic [2:0] REG_WAIT_FRAME   = 3'd0;
  localparam logic [2:0] REG_LOOP_ENABLE  = 3'd1;
  localparam logic [2:0] REG_CHIP_ENABLE  = 3'd2;
  localparam logic [2:0] REG_DATA_START   = 3'd3;
  localparam logic [2:0] REG_LOOP_ADDRESS = 3'd4;

  localparam logic [15:0] WAIT_FRAME_RESET  = 16'd882;
  localparam logic [2:0]  CHIP_ENABLE_RESET = 3'd7;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_OP1  = 2'd1,
    PH_OP2  = 2'd2,
    PH_OP3  = 2'd3
  } phase_t;

  // what the back end does with a word
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_ADD     = 3'd2,
    ACT_TICK    = 3'd3,
    ACT_RESTART = 3'd4,
    ACT_STOP    = 3'd5,
    ACT_STOPPED = 3'd6
  } act_t;

  typedef struct packed {
    act_t        act;
    logic [1:0]  chip;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic [15:0] amount;         // wait increment or restart address
    logic        stopped_after;
  } entry_t;

  function automatic logic [7:0] scc_base(input logic [7:0] idx);
    logic [7:0] base;
    case (idx)
      8'd1:    base = 8'h80;
      8'd2:    base = 8'h8A;
      8'd3:    base = 8'h8F;
      8'd4:    base = 8'hA0;
      8'd5:    base = 8'hE0;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vgm_command_stream_decoder.sv =====
// command stream decoder top: register port, parser, queue and executing back end
// throughput: one word per cycle while the queue has room; a two-word queue
// and the output register decouple the input from a stalled output
// reset: synchronous; parser idle, playing, wait count zero, registers at defaults
`default_nettype none

module vgm_command_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [1:0]       chip,
  output logic [7:0]       reg_addr,
  output logic [7:0]       reg_data,
  output logic [15:0]      restart_address,
  output logic             want_bytes,
  output logic             underrun,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] wait_frame;
  logic        loop_enable;
  logic [2:0]  chip_enable;
  logic [15:0] data_start;
  logic [15:0] loop_address;
  logic [2:0]  reg_index;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_frame   <= vgmcsd_pkg::WAIT_FRAME_RESET;
      loop_enable  <= 1'b0;
      chip_enable  <= vgmcsd_pkg::CHIP_ENABLE_RESET;
      data_start   <= 16'd0;
      loop_address <= 16'd0;
    end else if (cfg_write) begin
      case (reg_index)
        vgmcsd_pkg::REG_WAIT_FRAME:   wait_frame   <= pwdata[15:0];
        vgmcsd_pkg::REG_LOOP_ENABLE:  loop_enable  <= pwdata[0];
        vgmcsd_pkg::REG_CHIP_ENABLE:  chip_enable  <= pwdata[2:0];
        vgmcsd_pkg::REG_DATA_START:   data_start   <= pwdata[15:0];
        vgmcsd_pkg::REG_LOOP_ADDRESS: loop_address <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      vgmcsd_pkg::REG_WAIT_FRAME:   prdata = {16'd0, wait_frame};
      vgmcsd_pkg::REG_LOOP_ENABLE:  prdata = {31'd0, loop_enable};
      vgmcsd_pkg::REG_CHIP_ENABLE:  prdata = {29'd0, chip_enable};
      vgmcsd_pkg::REG_DATA_START:   prdata = {16'd0, data_start};
      vgmcsd_pkg::REG_LOOP_ADDRESS: prdata = {16'd0, loop_address};
      default:                      prdata = 32'd0;
    endcase
  end

  vgmcsd_pkg::entry_t front_entry, back_entry;
  logic accept, q_full, q_empty, q_pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  vgmcsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operation    (operation),
    .stream_byte  (stream_byte),
    .loop_enable  (loop_enable),
    .chip_enable  (chip_enable),
    .data_start   (data_start),
    .loop_address (loop_address),
    .entry        (front_entry)
  );

  vgmcsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (back_entry),
    .empty      (q_empty)
  );

  vgmcsd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .wait_frame      (wait_frame),
    .empty           (q_empty),
    .entry           (back_entry),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .chip            (chip),
    .reg_addr        (reg_addr),
    .reg_data        (reg_data),
    .restart_address (restart_address),
    .want_bytes      (want_bytes),
    .underrun        (underrun)
  );

endmodule

`default_nettype wire

// ===== hdl/vgmcsd_front.sv =====
// vgmcsd_front: parses stream bytes and classifies every word into a back-end action
// depends on vgmcsd_pkg
`default_nettype none

module vgmcsd_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [1:0]           operation,
  input  wire logic [7:0]           stream_byte,
  input  wire logic                 loop_enable,
  input  wire logic [2:0]           chip_enable,
  input  wire logic [15:0]          data_start,
  input  wire logic [15:0]          loop_address,
  output vgmcsd_pkg::entry_t        entry
);

  vgmcsd_pkg::phase_t phase, phase_next;
  logic [7:0] command, command_next;
  logic [7:0] first_operand, first_operand_next;
  logic [7:0] second_operand, second_operand_next;
  logic       stopped, stopped_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= vgmcsd_pkg::PH_CMD;
      command        <= 8'd0;
      first_operand  <= 8'd0;
      second_operand <= 8'd0;
      stopped        <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      command        <= command_next;
      first_operand  <= first_operand_next;
      second_operand <= second_operand_next;
      stopped        <= stopped_next;
    end
  end

  always_comb begin
    logic more;
    more                = 1'b0;
    phase_next          = phase;
    command_next        = command;
    first_operand_next  = first_operand;
    second_operand_next = second_operand;
    stopped_next        = stopped;
    entry               = '0;
    entry.act           = vgmcsd_pkg::ACT_NONE;

    if (operation == vgmcsd_pkg::OP_RESTART) begin
      stopped_next = 1'b0;
      phase_next   = vgmcsd_pkg::PH_CMD;
      entry.act    = vgmcsd_pkg::ACT_RESTART;
      entry.amount = data_start;
    end else if (stopped) begin
      entry.act = vgmcsd_pkg::ACT_STOPPED;
    end else if (operation == vgmcsd_pkg::OP_TICK) begin
      entry.act = vgmcsd_pkg::ACT_TICK;
    end else if (operation == vgmcsd_pkg::OP_BYTE) begin
      case (phase)
        vgmcsd_pkg::PH_CMD: begin
          if (stream_byte == vgmcsd_pkg::CMD_PSG || stream_byte == vgmcsd_pkg::CMD_WAIT) begin
            more = 1'b1;
          end else if (stream_byte == vgmcsd_pkg::CMD_SCC && chip_enable[0]) begin
            more = 1'b1;
          end else if (stream_byte == vgmcsd_pkg::CMD_FM && chip_enable[1]) begin
            more = 1'b1;
          end else if (stream_byte == vgmcsd_pkg::CMD_AUDIO && chip_enable[2]) begin
            more = 1'b1;
          end else if (stream_byte == vgmcsd_pkg::CMD_WAIT_60HZ) begin
            entry.act    = vgmcsd_pkg::ACT_ADD;
            entry.amount = vgmcsd_pkg::SAMPLES_60HZ;
          end else if (stream_byte == vgmcsd_pkg::CMD_WAIT_50HZ) begin
            entry.act    = vgmcsd_pkg::ACT_ADD;
            entry.amount = vgmcsd_pkg::SAMPLES_50HZ;
          end else if (stream_byte[7:4] == vgmcsd_pkg::CMD_SHORT_HI) begin
            entry.act    = vgmcsd_pkg::ACT_ADD;
            entry.amount = {12'd0, stream_byte[3:0]} + 16'd1;
          end else if (stream_byte == vgmcsd_pkg::CMD_END) begin
            if (loop_enable) begin
              entry.act    = vgmcsd_pkg::ACT_RESTART;
              entry.amount = (loop_address != 16'd0) ? loop_address : data_start;
            end else begin
              entry.act    = vgmcsd_pkg::ACT_STOP;
              stopped_next = 1'b1;
            end
          end
          if (more) begin
            command_next = stream_byte;
            phase_next   = vgmcsd_pkg::PH_OP1;
          end
        end
        vgmcsd_pkg::PH_OP1: begin
          first_operand_next = stream_byte;
          phase_next         = vgmcsd_pkg::PH_OP2;
        end
        default: begin
          if (phase == vgmcsd_pkg::PH_OP2 && command == vgmcsd_pkg::CMD_SCC) begin
            second_operand_next = stream_byte;
            phase_next          = vgmcsd_pkg::PH_OP3;
          end else begin
            // last byte of a multi-byte command
            phase_next = vgmcsd_pkg::PH_CMD;
            entry.addr = first_operand;
            entry.data = stream_byte;
            if (command == vgmcsd_pkg::CMD_PSG) begin
              entry.act  = vgmcsd_pkg::ACT_WRITE;
              entry.chip = vgmcsd_pkg::CHIP_PSG;
            end else if (command == vgmcsd_pkg::CMD_SCC) begin
              entry.act  = vgmcsd_pkg::ACT_WRITE;
              entry.chip = vgmcsd_pkg::CHIP_SCC;
              entry.addr = vgmcsd_pkg::scc_base(second_operand) + first_operand;
            end else if (command == vgmcsd_pkg::CMD_FM) begin
              entry.act  = vgmcsd_pkg::ACT_WRITE;
              entry.chip = vgmcsd_pkg::CHIP_FM;
            end else if (command == vgmcsd_pkg::CMD_AUDIO) begin
              entry.chip = vgmcsd_pkg::CHIP_AUDIO;
              if (first_operand != vgmcsd_pkg::AUD_REG_A &&
                  first_operand != vgmcsd_pkg::AUD_REG_B &&
                  first_operand != vgmcsd_pkg::AUD_REG_C) begin
                entry.act = vgmcsd_pkg::ACT_WRITE;
              end
              if (first_operand == vgmcsd_pkg::AUD_REG_MASK) begin
                entry.data = stream_byte & vgmcsd_pkg::AUD_MASK;
              end
            end else if (command == vgmcsd_pkg::CMD_WAIT) begin
              entry.act    = vgmcsd_pkg::ACT_ADD;
              entry.amount = {stream_byte, first_operand};
            end
          end
        end
      endcase
    end

    entry.stopped_after = stopped_next;
  end

endmodule

`default_nettype wire

// ===== hdl/vgmcsd_queue.sv =====
// vgmcsd_queue: two-word queue between the parser and the executing back end
// depends on vgmcsd_pkg
`default_nettype none

module vgmcsd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  vgmcsd_pkg::entry_t  push_entry,
  output logic                full,
  input  wire logic           pop,
  output vgmcsd_pkg::entry_t  pop_entry,
  output logic                empty
);

  vgmcsd_pkg::entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign pop_entry = slots[rd_ptr];

endmodule

`default_nettype wire

// ===== hdl/vgmcsd_back.sv =====
// vgmcsd_back: keeps the wait count and builds the registered result word
// depends on vgmcsd_pkg
`default_nettype none

module vgmcsd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [15:0]    wait_frame,
  input  wire logic           empty,
  input  vgmcsd_pkg::entry_t  entry,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          result_kind,
  output logic [1:0]          chip,
  output logic [7:0]          reg_addr,
  output logic [7:0]          reg_data,
  output logic [15:0]         restart_address,
  output logic                want_bytes,
  output logic                underrun
);

  logic [15:0] wait_count, wait_count_next;
  logic [1:0]  kind_next;
  logic [1:0]  chip_next;
  logic [7:0]  addr_next, data_next;
  logic [15:0] restart_next;
  logic        underrun_next;

  assign pop = !empty && (!out_valid || !out_stall);

  always_comb begin
    wait_count_next = wait_count;
    kind_next       = vgmcsd_pkg::KIND_NONE;
    chip_next       = 2'd0;
    addr_next       = 8'd0;
    data_next       = 8'd0;
    restart_next    = 16'd0;
    underrun_next   = 1'b0;
    case (entry.act)
      vgmcsd_pkg::ACT_WRITE: begin
        kind_next = vgmcsd_pkg::KIND_WRITE;
        chip_next = entry.chip;
        addr_next = entry.addr;
        data_next = entry.data;
      end
      vgmcsd_pkg::ACT_ADD: begin
        wait_count_next = wait_count + entry.amount;
      end
      vgmcsd_pkg::ACT_TICK: begin
        // short count clamps to zero
        if (wait_count < wait_frame) begin
          wait_count_next = 16'd0;
          underrun_next   = 1'b1;
        end else begin
          wait_count_next = wait_count - wait_frame;
        end
      end
      vgmcsd_pkg::ACT_RESTART: begin
        kind_next       = vgmcsd_pkg::KIND_RESTART;
        restart_next    = entry.amount;
        wait_count_next = 16'd0;
      end
      vgmcsd_pkg::ACT_STOP: begin
        kind_next       = vgmcsd_pkg::KIND_STOPPED;
        wait_count_next = 16'd0;
      end
      vgmcsd_pkg::ACT_STOPPED: begin
        kind_next = vgmcsd_pkg::KIND_STOPPED;
      end
      default: begin
        kind_next = vgmcsd_pkg::KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_count <= 16'd0;
      out_valid  <= 1'b0;
    end else if (pop) begin
      wait_count <= wait_count_next;
      out_valid  <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_kind     <= kind_next;
      chip            <= chip_next;
      reg_addr        <= addr_next;
      reg_data        <= data_next;
      restart_address <= restart_next;
      want_bytes      <= !entry.stopped_after && (wait_count_next < wait_frame);
      underrun        <= underrun_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vgmcsd_checker.sv =====
// vgmcsd_checker: port-level assertions on the decoder's result words
// bound to vgm_command_stream_decoder; depends on vgmcsd_pkg
`default_nettype none

module vgmcsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  result_kind,
  input wire logic [1:0]  chip,
  input wire logic [7:0]  reg_addr,
  input wire logic [7:0]  reg_data,
  input wire logic [15:0] restart_address,
  input wire logic        want_bytes,
  input wire logic        underrun
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(reg_data)
      && $stable(restart_address))
    else $error("stalled result word changed");

  // chip fields only carry a chip write
  a_write_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != vgmcsd_pkg::KIND_WRITE
      |-> chip == 2'd0 && reg_addr == 8'd0 && reg_data == 8'd0)
    else $error("chip fields set on a word that is not a chip write");

  a_restart_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != vgmcsd_pkg::KIND_RESTART |-> restart_address == 16'd0)
    else $error("restart address set on a word that is not a restart");

  // underrun clamps the count to zero, so more bytes are wanted
  a_underrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && underrun |-> result_kind == vgmcsd_pkg::KIND_NONE && want_bytes)
    else $error("underrun word inconsistent");

  a_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == vgmcsd_pkg::KIND_STOPPED |-> !want_bytes)
    else $error("stopped block still wants bytes");

endmodule

bind vgm_command_stream_decoder vgmcsd_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .result_kind     (result_kind),
  .chip            (chip),
  .reg_addr        (reg_addr),
  .reg_data        (reg_data),
  .restart_address (restart_address),
  .want_bytes      (want_bytes),
  .underrun        (underrun)
);

`default_nettype wire
